### rtl/core/pbs_pkg.sv
package pbs_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [2:0] {
		ST_OFF      = 3'd0,
		ST_SPINUP   = 3'd1,
		ST_WAITHOST = 3'd2,
		ST_ON       = 3'd3,
		ST_REQUEST  = 3'd4,
		ST_WAIT     = 3'd5,
		ST_HOLD     = 3'd6
	} seq_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLINK_HALF    = 4'd0,
		REG_SPINUP        = 4'd1,
		REG_SHUTDOWN_WAIT = 4'd2,
		REG_RELEASE_HOLD  = 4'd3
	} cfg_reg_t;

	localparam logic [2:0] LED_OFF = 3'b000;
	localparam logic [2:0] LED_R   = 3'b001;
	localparam logic [2:0] LED_G   = 3'b010;
	localparam logic [2:0] LED_B   = 3'b100;

	localparam logic [7:0] BLINK_HALF_RST    = 8'd25;
	localparam logic [9:0] SPINUP_RST        = 10'd50;
	localparam logic [9:0] SHUTDOWN_WAIT_RST = 10'd800;
	localparam logic [9:0] RELEASE_HOLD_RST  = 10'd100;

	typedef struct packed {
		logic [7:0] blink_half_period;
		logic [9:0] spinup_ticks;
		logic [9:0] shutdown_wait_ticks;
		logic [9:0] release_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] led_rgb;
		logic       fan_on;
		logic       host_power_on;
		logic       shutdown_request;
		logic [2:0] seq_state_code;
	} res_t;

endpackage

### rtl/core/pbs_if.sv
interface pbs_in_if;
	logic valid;
	logic ready;
	logic switch_pressed;
	logic host_up;

	modport source (output valid, output switch_pressed, output host_up, input ready);
	modport sink (input valid, input switch_pressed, input host_up, output ready);
endinterface

interface pbs_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] led_rgb;
	logic       fan_on;
	logic       host_power_on;
	logic       shutdown_request;
	logic [2:0] seq_state_code;

	modport source (
		output valid, output led_rgb, output fan_on, output host_power_on,
		output shutdown_request, output seq_state_code, input ready
	);
	modport sink (
		input valid, input led_rgb, input fan_on, input host_power_on,
		input shutdown_request, input seq_state_code, output ready
	);
endinterface

### rtl/core/pbs_cfg_regs.sv
module pbs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output pbs_pkg::cfg_t                  cfg
);

	pbs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_half_period   <= pbs_pkg::BLINK_HALF_RST;
			cfg_q.spinup_ticks        <= pbs_pkg::SPINUP_RST;
			cfg_q.shutdown_wait_ticks <= pbs_pkg::SHUTDOWN_WAIT_RST;
			cfg_q.release_hold_ticks  <= pbs_pkg::RELEASE_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbs_pkg::REG_BLINK_HALF:    cfg_q.blink_half_period   <= cfg_wdata[7:0];
				pbs_pkg::REG_SPINUP:        cfg_q.spinup_ticks        <= cfg_wdata[9:0];
				pbs_pkg::REG_SHUTDOWN_WAIT: cfg_q.shutdown_wait_ticks <= cfg_wdata[9:0];
				pbs_pkg::REG_RELEASE_HOLD:  cfg_q.release_hold_ticks  <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/pbs_fsm.sv
module pbs_fsm #(
	parameter int COUNTER_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          sw,
	input  logic          host,
	input  pbs_pkg::cfg_t cfg,
	output pbs_pkg::res_t res
);

	localparam int CW = (COUNTER_BITS > 10) ? COUNTER_BITS : 10;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	pbs_pkg::seq_state_t     state_q, state_d;
	logic [COUNTER_BITS-1:0] phase_q, phase_d, phase_inc;
	logic [7:0]              blink_cnt_q, blink_cnt_d;
	logic                    blink_q, blink_d;
	logic                    prev_sw_q, prev_host_q;
	logic [8:0]              blink_inc;
	logic                    press_ok, release_ok, host_ok, host_gone;
	logic [CW-1:0]           phase_ext;

	assign press_ok   = sw & prev_sw_q;
	assign release_ok = ~sw & ~prev_sw_q;
	assign host_ok    = host & prev_host_q;
	assign host_gone  = ~host & ~prev_host_q;

	// saturating count
	assign phase_inc = (phase_q == CNT_MAX) ? phase_q : phase_q + 1'b1;
	assign phase_ext = CW'(phase_inc);

	always_comb begin
		blink_inc = {1'b0, blink_cnt_q} + 9'd1;
		if (blink_inc >= {1'b0, cfg.blink_half_period}) begin
			blink_cnt_d = 8'd0;
			blink_d     = ~blink_q;
		end else begin
			blink_cnt_d = blink_inc[7:0];
			blink_d     = blink_q;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			pbs_pkg::ST_SPINUP: begin
				phase_d = phase_inc;
				if (phase_ext >= CW'(cfg.spinup_ticks))
					state_d = pbs_pkg::ST_WAITHOST;
			end
			pbs_pkg::ST_WAITHOST: begin
				if (host_ok)
					state_d = pbs_pkg::ST_ON;
			end
			pbs_pkg::ST_ON: begin
				if (host_gone) begin
					state_d = pbs_pkg::ST_WAIT;
					phase_d = '0;
				end else if (host && release_ok) begin
					state_d = pbs_pkg::ST_REQUEST;
				end
			end
			pbs_pkg::ST_REQUEST: begin
				if (host_gone) begin
					state_d = pbs_pkg::ST_WAIT;
					phase_d = '0;
				end
			end
			pbs_pkg::ST_WAIT: begin
				phase_d = phase_inc;
				if (phase_ext >= CW'(cfg.shutdown_wait_ticks)) begin
					state_d = pbs_pkg::ST_HOLD;
					phase_d = '0;
				end
			end
			pbs_pkg::ST_HOLD: begin
				if (sw) begin
					phase_d = '0;
				end else begin
					phase_d = phase_inc;
					if (phase_ext >= CW'(cfg.release_hold_ticks)) begin
						state_d = pbs_pkg::ST_OFF;
						phase_d = '0;
					end
				end
			end
			default: begin
				// off, and the unused code falls back to off
				state_d = pbs_pkg::ST_OFF;
				if (press_ok) begin
					phase_d = '0;
					state_d = (cfg.spinup_ticks == 10'd0) ? pbs_pkg::ST_WAITHOST
						: pbs_pkg::ST_SPINUP;
				end
			end
		endcase
	end

	// result reflects the state after this word's update
	always_comb begin
		res.fan_on           = 1'b0;
		res.host_power_on    = 1'b0;
		res.shutdown_request = 1'b0;
		res.seq_state_code   = state_d;
		unique case (state_d)
			pbs_pkg::ST_SPINUP: begin
				res.led_rgb = blink_d ? pbs_pkg::LED_G : pbs_pkg::LED_OFF;
				res.fan_on  = 1'b1;
			end
			pbs_pkg::ST_WAITHOST: begin
				res.led_rgb       = blink_d ? pbs_pkg::LED_G : pbs_pkg::LED_OFF;
				res.fan_on        = 1'b1;
				res.host_power_on = 1'b1;
			end
			pbs_pkg::ST_ON: begin
				res.led_rgb       = pbs_pkg::LED_G;
				res.fan_on        = 1'b1;
				res.host_power_on = 1'b1;
			end
			pbs_pkg::ST_REQUEST: begin
				res.led_rgb          = blink_d ? pbs_pkg::LED_R : pbs_pkg::LED_OFF;
				res.fan_on           = 1'b1;
				res.host_power_on    = 1'b1;
				res.shutdown_request = 1'b1;
			end
			pbs_pkg::ST_WAIT: begin
				res.led_rgb       = pbs_pkg::LED_R | pbs_pkg::LED_B;
				res.fan_on        = 1'b1;
				res.host_power_on = 1'b1;
			end
			pbs_pkg::ST_HOLD: begin
				res.led_rgb = pbs_pkg::LED_B;
			end
			default: begin
				res.led_rgb = pbs_pkg::LED_R;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbs_pkg::ST_OFF;
			phase_q     <= '0;
			blink_cnt_q <= 8'd0;
			blink_q     <= 1'b0;
			prev_sw_q   <= 1'b0;
			prev_host_q <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			blink_cnt_q <= blink_cnt_d;
			blink_q     <= blink_d;
			prev_sw_q   <= sw;
			prev_host_q <= host;
		end
	end

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(state_q) && $stable(phase_q) && $stable(blink_q))
		else $error("sequencer state moved without a word");

	a_hold_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == pbs_pkg::ST_HOLD && sw |=>
			state_q == pbs_pkg::ST_HOLD && phase_q == '0)
		else $error("press in hold did not restart release count");

	a_off_exits: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == pbs_pkg::ST_OFF |=>
			state_q == pbs_pkg::ST_OFF || state_q == pbs_pkg::ST_SPINUP
			|| state_q == pbs_pkg::ST_WAITHOST)
		else $error("illegal exit from off");

endmodule

### rtl/core/power_button_sequencer_top.sv
// A word accepted goes to the input register; its result goes to the output register once that is free or read.
// Throughput: one word per clock; while a result waits the input register still
// takes one word, and the input stalls once both registers are full.
// Reset (arst_n low, asynchronous): sequencer off, all counters and history cleared,
// registers back to blink 25, spin-up 50, shutdown wait 800, release hold 100 ticks.
module power_button_sequencer_top #(
	parameter int COUNTER_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pbs_in_if.sink                         in_ch,
	pbs_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [pbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	pbs_pkg::cfg_t cfg;
	pbs_pkg::res_t res_next;
	pbs_pkg::res_t res_s2;
	logic          valid_s1, valid_s2;
	logic          sw_s1, host_s1;
	logic          advance, in_take;

	assign advance = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take = in_ch.valid && in_ch.ready;

	pbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pbs_fsm #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sw     (sw_s1),
		.host   (host_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sw_s1   <= in_ch.switch_pressed;
			host_s1 <= in_ch.host_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.led_rgb          = res_s2.led_rgb;
	assign out_ch.fan_on           = res_s2.fan_on;
	assign out_ch.host_power_on    = res_s2.host_power_on;
	assign out_ch.shutdown_request = res_s2.shutdown_request;
	assign out_ch.seq_state_code   = res_s2.seq_state_code;

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sw_s1) && $stable(host_s1))
		else $error("pending word dropped from input register");

	a_no_overwrite_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |-> !advance)
		else $error("result register overwritten while waiting");

	a_req_only_in_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> out_ch.shutdown_request
			== (out_ch.seq_state_code == pbs_pkg::ST_REQUEST))
		else $error("shutdown request out of step with state");

	a_power_needs_fan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_ch.host_power_on |-> out_ch.fan_on)
		else $error("host power on without fan");

endmodule
